/* rtl/jvpp_pkg.sv */
// ----------------------------------------------------------------------------
// jvpp_pkg: shared types and constants
// Register indexes, configuration and per-joint state types, saturation helper.
// ----------------------------------------------------------------------------
package jvpp_pkg;

  localparam int JOINT_COUNT = 4;
  localparam int JOINT_W     = 2;
  localparam int VEL_W       = 16;
  localparam int GAIN_W      = 16;
  localparam int ERR_W       = VEL_W + 1;
  localparam int INTEG_W     = 32;
  localparam int SUM_W       = 36;
  localparam int PWM_W       = 8;
  localparam int DB_W        = 15;
  localparam int FRAC_BITS   = 20;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FF_GAIN     = 3'd0,
    REG_P_GAIN      = 3'd1,
    REG_I_GAIN      = 3'd2,
    REG_D_GAIN      = 3'd3,
    REG_DEADBAND    = 3'd4,
    REG_PWM_CEILING = 3'd5,
    REG_PWM_FLOOR   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0] ff_gain;
    logic [GAIN_W-1:0] p_gain;
    logic [GAIN_W-1:0] i_gain;
    logic [GAIN_W-1:0] d_gain;
    logic [DB_W-1:0]   deadband;
    logic [PWM_W-1:0]  pwm_ceiling;
    logic [PWM_W-1:0]  pwm_floor;
  } cfg_t;

  // state of one joint as read out of the store
  typedef struct packed {
    logic [INTEG_W-1:0] integrator;
    logic [ERR_W-1:0]   prev_error;
  } joint_state_t;

  // write-back request for one joint
  typedef struct packed {
    logic               en;
    logic               moving;
    logic [JOINT_W-1:0] joint;
    logic [INTEG_W-1:0] integrator;
    logic [ERR_W-1:0]   prev_error;
  } state_upd_t;

  function automatic logic signed [INTEG_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(signed'({1'b0, {(INTEG_W-1){1'b1}}}));
    lo = SUM_W'(signed'({1'b1, {(INTEG_W-1){1'b0}}}));
    if (v > hi) begin
      sat32 = hi[INTEG_W-1:0];
    end else if (v < lo) begin
      sat32 = lo[INTEG_W-1:0];
    end else begin
      sat32 = v[INTEG_W-1:0];
    end
  endfunction

endpackage

/* rtl/jvpp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// jvpp_cfg_regs: configuration register file
// Seven gain and limit registers written through an always-ready port.
// ----------------------------------------------------------------------------
module jvpp_cfg_regs import jvpp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ff_gain     <= 16'd256;
      cfg.p_gain      <= '0;
      cfg.i_gain      <= '0;
      cfg.d_gain      <= '0;
      cfg.deadband    <= 15'd2;
      cfg.pwm_ceiling <= 8'd50;
      cfg.pwm_floor   <= 8'd42;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_FF_GAIN:     cfg.ff_gain     <= cfg_data;
        REG_P_GAIN:      cfg.p_gain      <= cfg_data;
        REG_I_GAIN:      cfg.i_gain      <= cfg_data;
        REG_D_GAIN:      cfg.d_gain      <= cfg_data;
        REG_DEADBAND:    cfg.deadband    <= cfg_data[DB_W-1:0];
        REG_PWM_CEILING: cfg.pwm_ceiling <= cfg_data[PWM_W-1:0];
        REG_PWM_FLOOR:   cfg.pwm_floor   <= cfg_data[PWM_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

/* rtl/jvpp_joint_state.sv */
// ----------------------------------------------------------------------------
// jvpp_joint_state: per-joint integrator and previous error
// One read at the current joint, one write-back per processed item.
// ----------------------------------------------------------------------------
module jvpp_joint_state import jvpp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [JOINT_W-1:0] rd_joint,
  output joint_state_t       rd_state,
  input  state_upd_t         upd
);

  logic [INTEG_W-1:0] integrator [JOINT_COUNT];
  logic [ERR_W-1:0]   prev_error [JOINT_COUNT];

  assign rd_state.integrator = integrator[rd_joint];
  assign rd_state.prev_error = prev_error[rd_joint];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < JOINT_COUNT; i++) begin
        integrator[i] <= '0;
        prev_error[i] <= '0;
      end
    end else if (upd.en) begin
      // stop step clears the integrator and keeps the error history
      integrator[upd.joint] <= upd.moving ? upd.integrator : '0;
      if (upd.moving) begin
        prev_error[upd.joint] <= upd.prev_error;
      end
    end
  end

endmodule

/* rtl/jvpp_law.sv */
// ----------------------------------------------------------------------------
// jvpp_law: PID plus feedforward control law
// Gain products, saturating sums, truncation and pwm limit clamp.
// ----------------------------------------------------------------------------
module jvpp_law import jvpp_pkg::*; (
  input  cfg_t               cfg,
  input  joint_state_t       state,
  input  logic [VEL_W-1:0]   desired,
  input  logic [VEL_W-1:0]   measured,
  output logic               moving,
  output logic [INTEG_W-1:0] integ_new,
  output logic [ERR_W-1:0]   error,
  output logic [PWM_W-1:0]   magnitude
);

  logic signed [ERR_W-1:0]    des_s;
  logic signed [ERR_W-1:0]    meas_s;
  logic signed [ERR_W-1:0]    err_s;
  logic signed [ERR_W-1:0]    prev_s;
  logic signed [ERR_W:0]      derr_s;
  logic        [ERR_W-1:0]    des_abs;
  logic signed [GAIN_W-1:0]   ff_g;
  logic signed [GAIN_W-1:0]   p_g;
  logic signed [GAIN_W-1:0]   i_g;
  logic signed [GAIN_W-1:0]   d_g;
  logic signed [ERR_W+GAIN_W-1:0] ff_prod;
  logic signed [ERR_W+GAIN_W-1:0] p_prod;
  logic signed [ERR_W+GAIN_W-1:0] i_prod;
  logic signed [ERR_W+GAIN_W:0]   d_prod;
  logic signed [INTEG_W-1:0]  acc;
  logic signed [INTEG_W-1:0]  sum_sat;
  logic        [INTEG_W-1:0]  sum_abs;
  logic        [INTEG_W-FRAC_BITS-1:0] mag_raw;
  logic        [INTEG_W-FRAC_BITS-1:0] mag_cap;

  always_comb begin
    des_s  = signed'({desired[VEL_W-1], desired});
    meas_s = signed'({measured[VEL_W-1], measured});
    err_s  = des_s - meas_s;
    prev_s = signed'(state.prev_error);
    derr_s = (ERR_W+1)'(err_s) - (ERR_W+1)'(prev_s);
    des_abs = des_s[ERR_W-1] ? ERR_W'(-des_s) : ERR_W'(des_s);
    moving = des_abs > ERR_W'(cfg.deadband);

    ff_g = signed'(cfg.ff_gain);
    p_g  = signed'(cfg.p_gain);
    i_g  = signed'(cfg.i_gain);
    d_g  = signed'(cfg.d_gain);

    ff_prod = des_s * ff_g;
    p_prod  = err_s * p_g;
    i_prod  = err_s * i_g;
    d_prod  = derr_s * d_g;

    acc = sat32(SUM_W'(signed'(state.integrator)) + SUM_W'(i_prod));
    sum_sat = sat32(SUM_W'(ff_prod) + SUM_W'(p_prod) + SUM_W'(acc) + SUM_W'(d_prod));

    // most negative sum maps to 2^31, still fits unsigned 32 bits
    sum_abs = sum_sat[INTEG_W-1] ? INTEG_W'(-sum_sat) : INTEG_W'(sum_sat);
    mag_raw = sum_abs[INTEG_W-1:FRAC_BITS];

    mag_cap = (mag_raw > (INTEG_W-FRAC_BITS)'(cfg.pwm_ceiling))
            ? (INTEG_W-FRAC_BITS)'(cfg.pwm_ceiling) : mag_raw;
    // floor applied last, wins over ceiling
    if (mag_cap < (INTEG_W-FRAC_BITS)'(cfg.pwm_floor)) begin
      mag_cap = (INTEG_W-FRAC_BITS)'(cfg.pwm_floor);
    end

    magnitude = moving ? mag_cap[PWM_W-1:0] : '0;
    integ_new = acc;
    error     = err_s;
  end

endmodule

/* rtl/joint_velocity_pid_pwm.sv */
// ----------------------------------------------------------------------------
// joint_velocity_pid_pwm: per-joint velocity PID with feedforward to pwm
// Input register, single-pass control law with per-joint state, result register.
// ----------------------------------------------------------------------------
// One item is taken every clock cycle while item_stall is low, and its pwm result
// passes through the input register, then the result register. The whole control
// law runs combinationally between those registers, and the joint's integrator
// and previous error are written back as the result register loads, so items for the same
// joint may follow each other back to back. Configuration writes are always
// ready and should be made while no item is in flight.
module joint_velocity_pid_pwm import jvpp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic [JOINT_W-1:0]    joint_index,
  input  logic [VEL_W-1:0]      desired_velocity,
  input  logic [VEL_W-1:0]      measured_velocity,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [JOINT_W-1:0]    joint_out,
  output logic [PWM_W-1:0]      pwm_magnitude,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t               cfg;
  joint_state_t       rd_state;
  state_upd_t         upd;

  logic               s1_valid;
  logic [JOINT_W-1:0] s1_joint;
  logic [VEL_W-1:0]   s1_desired;
  logic [VEL_W-1:0]   s1_measured;

  logic               out_free;
  logic               s1_advance;
  logic               in_range;
  logic               moving;
  logic [INTEG_W-1:0] integ_new;
  logic [ERR_W-1:0]   error;
  logic [PWM_W-1:0]   law_mag;

  jvpp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  jvpp_joint_state u_state (
    .clk      (clk),
    .rst      (rst),
    .rd_joint (s1_joint),
    .rd_state (rd_state),
    .upd      (upd)
  );

  jvpp_law u_law (
    .cfg       (cfg),
    .state     (rd_state),
    .desired   (s1_desired),
    .measured  (s1_measured),
    .moving    (moving),
    .integ_new (integ_new),
    .error     (error),
    .magnitude (law_mag)
  );

  assign out_free   = !result_valid || !result_stall;
  assign s1_advance = s1_valid && out_free;
  assign item_stall = s1_valid && !out_free;
  assign in_range   = 32'(s1_joint) < JOINT_COUNT;

  always_comb begin
    upd.en         = s1_advance && in_range;
    upd.moving     = moving;
    upd.joint      = s1_joint;
    upd.integrator = integ_new;
    upd.prev_error = error;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_joint    <= joint_index;
      s1_desired  <= desired_velocity;
      s1_measured <= measured_velocity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      joint_out     <= s1_joint;
      pwm_magnitude <= in_range ? law_mag : '0;
    end
  end

endmodule
